### src/nns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nns_pkg - nearest neighbour search shared definitions
// Sizes, status codes, mode codes and the control structs passed between
// the sequencer and the distance unit.
// ----------------------------------------------------------------------------
package nns_pkg;

	localparam int MAX_POINTS  = 1024;
	localparam int MAX_DIMS    = 8;
	localparam int COORD_WIDTH = 16;

	// widths of the fields on the ports
	localparam int FIELD_W      = 16;
	localparam int NUM_FIELDS   = 8;
	localparam int MODE_W       = 2;
	localparam int STATUS_W     = 3;
	localparam int OUT_IDX_W    = 10;
	localparam int OUT_DIST_W   = 35;
	localparam int OUT_CNT_W    = 11;
	localparam int CFG_W        = 4;

	// internal widths
	localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DIMS_W = $clog2(MAX_DIMS + 1);
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int SQ_W   = 2 * COORD_WIDTH;
	localparam int DIST_W = SQ_W + DIMS_W;

	localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(2);

	localparam logic [MODE_W-1:0] MODE_ADD   = MODE_W'(0);
	localparam logic [MODE_W-1:0] MODE_QUERY = MODE_W'(1);
	localparam logic [MODE_W-1:0] MODE_CLEAR = MODE_W'(2);

	typedef enum logic [STATUS_W-1:0] {
		STAT_ADDED   = 3'd0,
		STAT_FULL    = 3'd1,
		STAT_FOUND   = 3'd2,
		STAT_EMPTY   = 3'd3,
		STAT_CLEARED = 3'd4
	} status_t;

	typedef logic [MAX_DIMS-1:0][COORD_WIDTH-1:0] row_t;

	// one coordinate step issued by the sequencer
	typedef struct packed {
		logic             valid;
		logic             first_dim;
		logic             last_dim;
		logic             first_point;
		logic             last_point;
		logic [DIM_W-1:0] dim;
		logic [IDX_W-1:0] idx;
	} scan_ctl_t;

	// outcome of a finished scan
	typedef struct packed {
		logic              done;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] best_dist;
	} scan_res_t;

endpackage
`default_nettype wire

### src/nns_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nns_in_if - request channel
// Valid/ready channel carrying the mode and the eight coordinate fields.
// ----------------------------------------------------------------------------
interface nns_in_if;
	import nns_pkg::*;

	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [FIELD_W-1:0]  coord_0;
	logic [FIELD_W-1:0]  coord_1;
	logic [FIELD_W-1:0]  coord_2;
	logic [FIELD_W-1:0]  coord_3;
	logic [FIELD_W-1:0]  coord_4;
	logic [FIELD_W-1:0]  coord_5;
	logic [FIELD_W-1:0]  coord_6;
	logic [FIELD_W-1:0]  coord_7;

	modport source (
		output valid, mode, coord_0, coord_1, coord_2, coord_3,
		       coord_4, coord_5, coord_6, coord_7,
		input  ready
	);

	modport sink (
		input  valid, mode, coord_0, coord_1, coord_2, coord_3,
		       coord_4, coord_5, coord_6, coord_7,
		output ready
	);

endinterface
`default_nettype wire

### src/nns_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nns_out_if - result channel
// Valid/ready channel carrying status, index, distance and point count.
// ----------------------------------------------------------------------------
interface nns_out_if;
	import nns_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [OUT_IDX_W-1:0]  best_index;
	logic [OUT_DIST_W-1:0] best_distance;
	logic [OUT_CNT_W-1:0]  point_count;

	modport source (
		output valid, status, best_index, best_distance, point_count,
		input  ready
	);

	modport sink (
		input  valid, status, best_index, best_distance, point_count,
		output ready
	);

endinterface
`default_nettype wire

### src/nns_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nns_store - point memory
// One row per point holding all coordinates; one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module nns_store (
	input  wire                       clk,
	input  wire                       we,
	input  wire [nns_pkg::IDX_W-1:0]  waddr,
	input  wire nns_pkg::row_t        wdata,
	input  wire [nns_pkg::IDX_W-1:0]  raddr,
	output nns_pkg::row_t             rdata
);
	import nns_pkg::*;

	row_t mem [MAX_POINTS];
	row_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### src/nns_dist.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nns_dist - shared distance unit
// One coordinate per cycle: subtract, square, accumulate, and on the last
// coordinate of a point compare against the running best.
// ----------------------------------------------------------------------------
module nns_dist (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire nns_pkg::scan_ctl_t  issue,
	input  wire nns_pkg::row_t       row,
	input  wire nns_pkg::row_t       query,
	output nns_pkg::scan_res_t       res
);
	import nns_pkg::*;

	scan_ctl_t               ctl_s1, ctl_s2, ctl_s3;
	logic [COORD_WIDTH-1:0]  abs_s2;
	logic [SQ_W-1:0]         sq_s3;
	logic [DIST_W-1:0]       acc_q;
	logic [DIST_W-1:0]       best_q;
	logic [IDX_W-1:0]        best_idx_q;
	logic                    done_q;

	logic signed [DIFF_W-1:0] pt_c, qv_c, diff_c;
	logic [DIFF_W-1:0]        mag_c;
	logic [DIST_W-1:0]        sum_c;

	// memory data lines up with ctl_s1
	always_comb begin
		pt_c   = DIFF_W'($signed(row[ctl_s1.dim]));
		qv_c   = DIFF_W'($signed(query[ctl_s1.dim]));
		diff_c = pt_c - qv_c;
		mag_c  = diff_c[DIFF_W-1] ? DIFF_W'(-diff_c) : DIFF_W'(diff_c);
		sum_c  = (ctl_s3.first_dim ? '0 : acc_q) + DIST_W'(sq_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1     <= '0;
			ctl_s2     <= '0;
			ctl_s3     <= '0;
			abs_s2     <= '0;
			sq_s3      <= '0;
			acc_q      <= '0;
			best_q     <= '0;
			best_idx_q <= '0;
			done_q     <= 1'b0;
		end else begin
			ctl_s1 <= issue;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			abs_s2 <= mag_c[COORD_WIDTH-1:0];
			sq_s3  <= abs_s2 * abs_s2;
			done_q <= ctl_s3.valid && ctl_s3.last_dim && ctl_s3.last_point;
			if (ctl_s3.valid) begin
				acc_q <= sum_c;
				// strict compare keeps the lowest index on a tie
				if (ctl_s3.last_dim && (ctl_s3.first_point || sum_c < best_q)) begin
					best_q     <= sum_c;
					best_idx_q <= ctl_s3.idx;
				end
			end
		end
	end

	assign res.done      = done_q;
	assign res.idx       = best_idx_q;
	assign res.best_dist = best_q;

endmodule
`default_nettype wire

### src/nearest_neighbor_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbor_search - brute force nearest neighbour block
// Stores points and answers squared-distance nearest point queries, with
// add, query and clear operations selected per request.
// ----------------------------------------------------------------------------
//  port       dir   kind             beat carries
//  in_ch      in    valid/ready      mode, coord_0 .. coord_7
//  out_ch     out   valid/ready      status, best_index, best_distance,
//                                    point_count
//  cfg_we     in    write strobe     cfg_wdata: dimensions, clears the store
//
//  add, clear and empty query: the response state loads the result beat
//  once the output register is free, and returns to idle as it is offered
//  query: every dimension of every stored point goes through the one
//  distance unit, then the drain and response states give the result beat
//  one request at a time: in_ch.ready is high only while idle and no
//  dimensions write is present
//  the result register holds its beat until out_ch takes it
//  reset: point count zero, dimensions 2, memory contents left undefined
// ----------------------------------------------------------------------------
module nearest_neighbor_search (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire [nns_pkg::CFG_W-1:0]  cfg_wdata,
	nns_in_if.sink                    in_ch,
	nns_out_if.source                 out_ch
);
	import nns_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESP
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [DIMS_W-1:0]    dims_q;
	logic [IDX_W-1:0]     i_q;
	logic [DIM_W-1:0]     d_q;
	row_t                 query_q;

	status_t              res_status_q;
	logic [IDX_W-1:0]     res_idx_q;
	logic [DIST_W-1:0]    res_dist_q;
	logic [CNT_W-1:0]     res_count_q;

	logic                 ov_q;
	status_t              out_status_q;
	logic [OUT_IDX_W-1:0] out_idx_q;
	logic [OUT_DIST_W-1:0] out_dist_q;
	logic [OUT_CNT_W-1:0] out_count_q;

	logic [FIELD_W-1:0]   field_c [NUM_FIELDS];
	row_t                 row_c;
	logic                 accept_c;
	logic                 out_free_c;
	logic                 last_dim_c;
	logic                 last_point_c;
	logic [DIMS_W-1:0]    cfg_dims_c;
	scan_ctl_t            issue_c;
	scan_res_t            res_c;
	row_t                 rd_row;
	logic                 we_c;

	assign field_c[0] = in_ch.coord_0;
	assign field_c[1] = in_ch.coord_1;
	assign field_c[2] = in_ch.coord_2;
	assign field_c[3] = in_ch.coord_3;
	assign field_c[4] = in_ch.coord_4;
	assign field_c[5] = in_ch.coord_5;
	assign field_c[6] = in_ch.coord_6;
	assign field_c[7] = in_ch.coord_7;

	// each field is COORD_WIDTH wide and kept whole, sign lives in the top one
	always_comb begin
		for (int k = 0; k < MAX_DIMS; k++) begin
			row_c[k] = field_c[k][COORD_WIDTH-1:0];
		end
	end

	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_dims_c = DIMS_W'(1);
		end else if (CFG_W'(cfg_wdata) > CFG_W'(MAX_DIMS)) begin
			cfg_dims_c = DIMS_W'(MAX_DIMS);
		end else begin
			cfg_dims_c = DIMS_W'(cfg_wdata);
		end
	end

	// a dimensions write takes the cycle, no request beat alongside it
	assign in_ch.ready  = (state_q == ST_IDLE) && !cfg_we;
	assign accept_c     = in_ch.valid && in_ch.ready;
	assign out_free_c   = !ov_q || out_ch.ready;
	assign last_dim_c   = (DIMS_W'(d_q) + DIMS_W'(1)) == dims_q;
	assign last_point_c = (CNT_W'(i_q) + CNT_W'(1)) == count_q;

	assign we_c = accept_c && (in_ch.mode == MODE_ADD) && (count_q != CNT_W'(MAX_POINTS));

	always_comb begin
		issue_c.valid       = (state_q == ST_SCAN);
		issue_c.first_dim   = (d_q == '0);
		issue_c.last_dim    = last_dim_c;
		issue_c.first_point = (i_q == '0);
		issue_c.last_point  = last_point_c;
		issue_c.dim         = d_q;
		issue_c.idx         = i_q;
	end

	nns_store u_store (
		.clk   (clk),
		.we    (we_c),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (row_c),
		.raddr (i_q),
		.rdata (rd_row)
	);

	nns_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue_c),
		.row    (rd_row),
		.query  (query_q),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			dims_q       <= DIMS_RESET;
			i_q          <= '0;
			d_q          <= '0;
			query_q      <= '0;
			res_status_q <= STAT_CLEARED;
			res_idx_q    <= '0;
			res_dist_q   <= '0;
			res_count_q  <= '0;
			ov_q         <= 1'b0;
			out_status_q <= STAT_CLEARED;
			out_idx_q    <= '0;
			out_dist_q   <= '0;
			out_count_q  <= '0;
		end else begin
			// in the response state the output register is handled below
			if (ov_q && out_ch.ready && (state_q != ST_RESP)) begin
				ov_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept_c) begin
						query_q    <= row_c;
						i_q        <= '0;
						d_q        <= '0;
						res_idx_q  <= '0;
						res_dist_q <= '0;
						state_q    <= ST_RESP;
						if (in_ch.mode == MODE_CLEAR) begin
							count_q      <= '0;
							res_count_q  <= '0;
							res_status_q <= STAT_CLEARED;
						end else if (in_ch.mode == MODE_ADD) begin
							if (count_q == CNT_W'(MAX_POINTS)) begin
								res_status_q <= STAT_FULL;
								res_count_q  <= count_q;
							end else begin
								res_status_q <= STAT_ADDED;
								res_idx_q    <= count_q[IDX_W-1:0];
								count_q      <= count_q + CNT_W'(1);
								res_count_q  <= count_q + CNT_W'(1);
							end
						end else begin
							// query, the reserved mode falls in here too
							res_count_q <= count_q;
							if (count_q == '0) begin
								res_status_q <= STAT_EMPTY;
							end else begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					if (last_dim_c) begin
						d_q <= '0;
						if (last_point_c) begin
							state_q <= ST_DRAIN;
						end else begin
							i_q <= i_q + IDX_W'(1);
						end
					end else begin
						d_q <= d_q + DIM_W'(1);
					end
				end
				ST_DRAIN: begin
					if (res_c.done) begin
						res_status_q <= STAT_FOUND;
						res_idx_q    <= res_c.idx;
						res_dist_q   <= res_c.best_dist;
						state_q      <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free_c) begin
						ov_q         <= 1'b1;
						out_status_q <= res_status_q;
						out_idx_q    <= OUT_IDX_W'(res_idx_q);
						out_dist_q   <= OUT_DIST_W'(res_dist_q);
						out_count_q  <= OUT_CNT_W'(res_count_q);
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// dimension change empties the store
			if (cfg_we) begin
				dims_q  <= cfg_dims_c;
				count_q <= '0;
			end
		end
	end

	assign out_ch.valid         = ov_q;
	assign out_ch.status        = out_status_q;
	assign out_ch.best_index    = out_idx_q;
	assign out_ch.best_distance = out_dist_q;
	assign out_ch.point_count   = out_count_q;

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept_c |=> !in_ch.ready)
		else $error("request channel ready right after a request beat");

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_c.done |-> (state_q == ST_DRAIN))
		else $error("scan finished outside the drain state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("stored point count beyond capacity");

	a_found_index: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_status_q == STAT_FOUND) |->
			(OUT_CNT_W'(out_idx_q) < out_count_q))
		else $error("nearest index not below the point count");

endmodule
`default_nettype wire

### verif/tb_nearest_neighbor_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_search - self-checking bench for the neighbour search
// Drives add, query and clear requests with random idle gaps and result
// stalls, keeps its own copy of the point store, and checks every result
// beat field by field against the predicted nearest point and distance.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_search;
	import nns_pkg::*;

	localparam logic [MODE_W-1:0] MODE_RESERVED = MODE_W'(3);

	typedef struct {
		status_t               status;
		logic [OUT_IDX_W-1:0]  index;
		logic [OUT_DIST_W-1:0] distance;
		logic [OUT_CNT_W-1:0]  count;
	} nearest_result_t;

	// mirror of the point store plus the queue of results still owed
	class neighbour_scoreboard;
		row_t            point_rows [MAX_POINTS];
		int unsigned     stored_count;
		int unsigned     dims;
		nearest_result_t expected_q [$];
		int unsigned     mismatches;
		int unsigned     status_seen [5];

		function new();
			stored_count = 0;
			dims = 2;
			mismatches = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void set_dimensions(logic [CFG_W-1:0] v);
			if (v == 0)
				dims = 1;
			else if (v > MAX_DIMS)
				dims = MAX_DIMS;
			else
				dims = v;
			stored_count = 0;
		endfunction

		function void note_request(logic [MODE_W-1:0] mode, row_t c);
			nearest_result_t r;
			longint          diff;
			longint unsigned sum;
			longint unsigned best;
			int unsigned     best_idx;
			bit              have;
			best = 0;
			best_idx = 0;
			have = 0;
			if (mode == MODE_CLEAR) begin
				stored_count = 0;
				r.status = STAT_CLEARED;
			end else if (mode == MODE_ADD) begin
				if (stored_count >= MAX_POINTS) begin
					r.status = STAT_FULL;
				end else begin
					point_rows[stored_count] = c;
					best_idx = stored_count;
					stored_count++;
					r.status = STAT_ADDED;
				end
			end else begin
				// strict less-than keeps the lowest index on a tie
				for (int i = 0; i < stored_count; i++) begin
					sum = 0;
					for (int d = 0; d < dims; d++) begin
						diff = longint'($signed(point_rows[i][d])) - longint'($signed(c[d]));
						sum += longint'(diff * diff);
					end
					if (!have || sum < best) begin
						have = 1;
						best = sum;
						best_idx = i;
					end
				end
				r.status = have ? STAT_FOUND : STAT_EMPTY;
			end
			r.index    = OUT_IDX_W'(best_idx);
			r.distance = OUT_DIST_W'(best);
			r.count    = OUT_CNT_W'(stored_count);
			status_seen[r.status]++;
			expected_q.push_back(r);
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [OUT_IDX_W-1:0] idx,
				logic [OUT_DIST_W-1:0] dst, logic [OUT_CNT_W-1:0] cnt);
			nearest_result_t want;
			if (expected_q.size() == 0) begin
				flag($sformatf("unrequested beat: status %0d index %0d distance %0d count %0d",
					st, idx, dst, cnt));
				return;
			end
			want = expected_q.pop_front();
			if (st !== want.status)
				flag($sformatf("status expected %0d got %0d", want.status, st));
			if (idx !== want.index)
				flag($sformatf("best_index expected %0d got %0d", want.index, idx));
			if (dst !== want.distance)
				flag($sformatf("best_distance expected %0d got %0d", want.distance, dst));
			if (cnt !== want.count)
				flag($sformatf("point_count expected %0d got %0d", want.count, cnt));
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	nns_in_if  in_ch ();
	nns_out_if out_ch ();

	neighbour_scoreboard sb = new();

	bit          tx_calm;
	bit          rx_calm;
	int unsigned cfg_writes;

	nearest_neighbor_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned idle_len(bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 9);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [FIELD_W-1:0] pick_coord();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			case ($urandom_range(0, 3))
				0: return 16'h8000;
				1: return 16'h7fff;
				2: return 16'h0000;
				default: return 16'hffff;
			endcase
		end
		// small values give plenty of equal distances
		if (r < 45)
			return FIELD_W'(int'($urandom_range(0, 12)) - 6);
		return FIELD_W'($urandom);
	endfunction

	function automatic row_t rand_row();
		row_t c;
		for (int d = 0; d < MAX_DIMS; d++)
			c[d] = pick_coord();
		return c;
	endfunction

	task automatic send_request(input logic [MODE_W-1:0] mode, input row_t c);
		int unsigned gap;
		in_ch.valid   <= 1'b1;
		in_ch.mode    <= mode;
		in_ch.coord_0 <= c[0];
		in_ch.coord_1 <= c[1];
		in_ch.coord_2 <= c[2];
		in_ch.coord_3 <= c[3];
		in_ch.coord_4 <= c[4];
		in_ch.coord_5 <= c[5];
		in_ch.coord_6 <= c[6];
		in_ch.coord_7 <= c[7];
		do @(posedge clk); while (!in_ch.ready);
		sb.note_request(mode, c);
		if ($urandom_range(0, 39) == 0)
			tx_calm = !tx_calm;
		gap = idle_len(tx_calm);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		if (in_ch.valid)
			in_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	// a dimensions write also empties the store
	task automatic write_dimensions(input logic [CFG_W-1:0] v);
		if (in_ch.valid)
			in_ch.valid <= 1'b0;
		while (sb.expected_q.size() != 0 || !in_ch.ready) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_dimensions(v);
		cfg_writes++;
	endtask

	// result side: random back-pressure
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		rx_calm = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.status, out_ch.best_index,
					out_ch.best_distance, out_ch.point_count);
			if ($urandom_range(0, 149) == 0)
				rx_calm = !rx_calm;
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				stall_left = idle_len(rx_calm);
			end
		end
	end

	initial begin
		#50_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		row_t             c;
		logic [MODE_W-1:0] m;
		int unsigned      r;
		logic [CFG_W-1:0] dims_plan [6];
		tx_calm    = 1'b0;
		cfg_writes = 0;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		in_ch.valid   <= 1'b0;
		in_ch.mode    <= MODE_ADD;
		in_ch.coord_0 <= '0;
		in_ch.coord_1 <= '0;
		in_ch.coord_2 <= '0;
		in_ch.coord_3 <= '0;
		in_ch.coord_4 <= '0;
		in_ch.coord_5 <= '0;
		in_ch.coord_6 <= '0;
		in_ch.coord_7 <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// two dimensions out of reset; higher coordinates carry noise
		send_request(MODE_QUERY, rand_row());
		c = rand_row(); c[0] = 16'h0000; c[1] = 16'h0000;
		send_request(MODE_ADD, c);
		c = rand_row(); c[0] = 16'h8000; c[1] = 16'h7fff;
		send_request(MODE_ADD, c);
		c = rand_row(); c[0] = 16'h7fff; c[1] = 16'h8000;
		send_request(MODE_ADD, c);
		c = rand_row(); c[0] = 16'h0000; c[1] = 16'h0000;
		send_request(MODE_ADD, c);
		c = rand_row(); c[0] = 16'h0000; c[1] = 16'h0000;
		send_request(MODE_QUERY, c);
		c = rand_row(); c[0] = 16'h8000; c[1] = 16'h8000;
		send_request(MODE_RESERVED, c);
		c = rand_row(); c[0] = 16'h7fff; c[1] = 16'h7fff;
		send_request(MODE_QUERY, c);
		c = rand_row(); c[0] = 16'h0001; c[1] = 16'hffff;
		send_request(MODE_QUERY, c);
		send_request(MODE_CLEAR, rand_row());
		send_request(MODE_QUERY, rand_row());

		// all eight dimensions: the largest possible distance
		write_dimensions(4'd8);
		send_request(MODE_ADD, {MAX_DIMS{16'h8000}});
		send_request(MODE_QUERY, {MAX_DIMS{16'h7fff}});
		send_request(MODE_ADD, {MAX_DIMS{16'h7fff}});
		send_request(MODE_QUERY, '0);
		send_request(MODE_RESERVED, {MAX_DIMS{16'h7fff}});

		// zero saturates to one dimension; a long run of adds, then long scans
		write_dimensions(4'd0);
		for (int i = 0; i < 190; i++)
			send_request(MODE_ADD, rand_row());
		send_request(MODE_QUERY, rand_row());
		send_request(MODE_RESERVED, rand_row());
		send_request(MODE_CLEAR, rand_row());

		dims_plan = '{4'd15, 4'd1, 4'd3, 4'd8, 4'd5, 4'd2};
		dims_plan[4] = CFG_W'($urandom_range(0, 15));
		for (int p = 0; p < 6; p++) begin
			write_dimensions(dims_plan[p]);
			for (int i = 0; i < 62; i++) begin
				if (i == 31)
					wait_for_results();
				r = $urandom_range(0, 99);
				c = rand_row();
				// clear more often once the store grows, to keep scans short
				if (r < 4 || (sb.stored_count > 48 && r < 20)) begin
					m = MODE_CLEAR;
				end else if (r < 55) begin
					m = MODE_ADD;
					if (sb.stored_count > 0 && $urandom_range(0, 9) == 0)
						c = sb.point_rows[$urandom_range(0, sb.stored_count - 1)];
				end else begin
					m = (r < 63) ? MODE_RESERVED : MODE_QUERY;
					if (sb.stored_count > 0 && $urandom_range(0, 2) == 0) begin
						c = sb.point_rows[$urandom_range(0, sb.stored_count - 1)];
						c[0] = c[0] + FIELD_W'($urandom_range(0, 2)) - FIELD_W'(1);
					end
				end
				send_request(m, c);
			end
		end

		wait_for_results();
		repeat (20) @(posedge clk);
		$display("covered %0d adds, %0d dropped on a full store, %0d found, %0d empty queries, %0d clears",
			sb.status_seen[STAT_ADDED], sb.status_seen[STAT_FULL], sb.status_seen[STAT_FOUND],
			sb.status_seen[STAT_EMPTY], sb.status_seen[STAT_CLEARED]);
		$display("%0d dimension writes incl. saturating values, %0d mismatches",
			cfg_writes, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### filelist.f
src/nns_pkg.sv
src/nns_in_if.sv
src/nns_out_if.sv
src/nns_store.sv
src/nns_dist.sv
src/nearest_neighbor_search.sv
verif/tb_nearest_neighbor_search.sv
